// ----- rtl/cqe_pkg.sv -----
// Shared types, constants and tables for the composite quadrature engine.
// No dependencies; every other file refers to it by scoped names.
package cqe_pkg;

    // Request limits and field widths
    localparam int MAX_INTERVALS     = 65536;
    localparam int IN_W              = 17;
    localparam int CNT_W             = $clog2(MAX_INTERVALS + 1);
    localparam int CORDIC_ITERATIONS = 28;

    // Datapath widths
    localparam int XW     = 32;                          // Q3.28 abscissa and bounds
    localparam int SPAN_W = XW + 1;                      // b - a
    localparam int ANG_W  = XW + 2;                      // 2x + 1 before reduction
    localparam int ZW     = 32;                          // CORDIC x, y, z
    localparam int TERM_W = XW + 3;                      // f times weight 1, 2 or 4
    localparam int QA_W   = SPAN_W + 2;                  // running floor(i*span/n)
    localparam int DSR_W  = $clog2(3 * MAX_INTERVALS + 1);
    localparam int DIV_W  = DSR_W + 34;                  // weighted sum magnitude
    localparam int MUL_W  = XW;                          // |mean| bits
    localparam int PROD_W = MUL_W + SPAN_W;              // |mean| * |span|
    localparam int RES_W  = 40;

    // Function pipeline: angle, reduction, fold, rotations, multiply, scale
    localparam int RED_STAGES   = 4;
    localparam int FUNC_LATENCY = CORDIC_ITERATIONS + RED_STAGES + 4;

    // Q28 constants
    localparam logic signed [ANG_W-1:0] Q_ONE       = ANG_W'(268435456);
    localparam logic signed [ANG_W-1:0] Q_PI        = ANG_W'(843314857);
    localparam logic signed [ANG_W-1:0] Q_HALF_PI   = ANG_W'(421657428);
    localparam logic signed [ANG_W-1:0] Q_TWO_PI    = ANG_W'(1686629713);
    localparam logic signed [ZW-1:0]    CORDIC_GAIN = ZW'(163008218);

    // Reset values of the bounds
    localparam logic signed [XW-1:0] LOWER_RESET = -XW'(268435456);
    localparam logic signed [XW-1:0] UPPER_RESET = XW'(268435456);

    // Register indexes on the configuration port
    localparam logic REG_LOWER = 1'b0;
    localparam logic REG_UPPER = 1'b1;

    typedef enum logic [1:0] {
        CMD_LEFT    = 2'd0,
        CMD_RIGHT   = 2'd1,
        CMD_TRAP    = 2'd2,
        CMD_SIMPSON = 2'd3
    } t_cmd;

    typedef struct packed {
        logic [CNT_W-1:0] n;
        t_cmd             cmd;
        logic             err;
    } t_job;

    typedef struct packed {
        logic signed [RES_W-1:0] integral;
        logic                    err;
    } t_result;

    // Arctangent of 2^-i in Q28
    function automatic logic signed [ZW-1:0] atan_entry(input int i);
        logic signed [ZW-1:0] v;
        v = '0;
        if (i < 12) begin
            case (i)
                0:       v = ZW'(210828714);
                1:       v = ZW'(124459457);
                2:       v = ZW'(65760959);
                3:       v = ZW'(33381290);
                4:       v = ZW'(16755422);
                5:       v = ZW'(8385879);
                6:       v = ZW'(4193963);
                7:       v = ZW'(2097109);
                8:       v = ZW'(1048571);
                9:       v = ZW'(524287);
                10:      v = ZW'(262144);
                default: v = ZW'(131072);
            endcase
        end else if (i <= 28) begin
            v = ZW'(1) <<< (28 - i);
        end
        return v;
    endfunction

endpackage

// ----- rtl/composite_quadrature_engine.sv -----
// Top level of the composite quadrature engine: configuration registers,
// result queue, front end and back end. Uses cqe_pkg, cqe_front, cqe_back.
//
// Usage:
//   Requests enter through push/full with i_intervals and i_command
//   (left, right, trapezoid, Simpson). Results leave through empty/pop with
//   o_integral (signed Q11.28) and o_error_flag; the oldest result sits on
//   the ports while empty is low.
//   Bounds a and b are written through i_cfg_valid/o_cfg_ready with
//   i_cfg_index and i_cfg_data; write them only while the block is idle.
//   Flow: a rejected request (zero count, odd Simpson count) skips the
//   computation and goes on to the result ports. A valid one passes
//   through two restoring divisions (step, then mean) around a sweep over
//   the n + 1 abscissae through the pipelined CORDIC unit and a pipeline
//   drain, then a shift-add multiply and the handoff registers.
//   Throughput: one request at a time in the back end; two requests and two
//   results can wait in the queues.
//   Reset (synchronous, active low) empties both queues, returns the
//   sequencer to idle and sets a = -1.0, b = +1.0.
//   When the receiver stalls, the result queue fills, the back end holds its
//   finished result, and then full rises once the job queue is full.
module composite_quadrature_engine (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             push,
    output logic                             full,
    input  logic [cqe_pkg::IN_W-1:0]         i_intervals,
    input  logic [1:0]                       i_command,
    output logic                             empty,
    input  logic                             pop,
    output logic signed [cqe_pkg::RES_W-1:0] o_integral,
    output logic                             o_error_flag,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic                             i_cfg_index,
    input  logic [cqe_pkg::XW-1:0]           i_cfg_data
);

    logic signed [cqe_pkg::XW-1:0] r_lower;
    logic signed [cqe_pkg::XW-1:0] r_upper;

    logic             job_valid;
    logic             job_ready;
    cqe_pkg::t_job    job;
    logic             res_valid;
    logic             res_ready;
    cqe_pkg::t_result res;

    cqe_pkg::t_result r_rq [2];
    logic             r_rq_wr;
    logic             r_rq_rd;
    logic [1:0]       r_rq_cnt;
    logic             rq_push;
    logic             rq_pop;

    // Configuration registers
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lower <= cqe_pkg::LOWER_RESET;
            r_upper <= cqe_pkg::UPPER_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            if (i_cfg_index == cqe_pkg::REG_LOWER) begin
                r_lower <= i_cfg_data;
            end
            if (i_cfg_index == cqe_pkg::REG_UPPER) begin
                r_upper <= i_cfg_data;
            end
        end
    end

    cqe_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .push        (push),
        .full        (full),
        .i_intervals (i_intervals),
        .i_command   (i_command),
        .o_job_valid (job_valid),
        .o_job       (job),
        .i_job_ready (job_ready)
    );

    cqe_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (job_valid),
        .i_job       (job),
        .o_job_ready (job_ready),
        .i_lower     (r_lower),
        .i_upper     (r_upper),
        .o_res_valid (res_valid),
        .o_res       (res),
        .i_res_ready (res_ready)
    );

    // Result queue
    assign res_ready    = (r_rq_cnt != 2'd2);
    assign rq_push      = res_valid && res_ready;
    assign empty        = (r_rq_cnt == 2'd0);
    assign rq_pop       = pop && !empty;
    assign o_integral   = r_rq[r_rq_rd].integral;
    assign o_error_flag = r_rq[r_rq_rd].err;

    always_ff @(posedge i_clk) begin
        if (rq_push) begin
            r_rq[r_rq_wr] <= res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rq_wr  <= 1'b0;
            r_rq_rd  <= 1'b0;
            r_rq_cnt <= 2'd0;
        end else begin
            if (rq_push) begin
                r_rq_wr <= ~r_rq_wr;
            end
            if (rq_pop) begin
                r_rq_rd <= ~r_rq_rd;
            end
            r_rq_cnt <= r_rq_cnt + 2'(rq_push) - 2'(rq_pop);
        end
    end

endmodule

// ----- rtl/cqe_front.sv -----
// Front end: accepts requests, saturates the count, flags bad requests and
// queues jobs for the back end. Depends on cqe_pkg.
module cqe_front (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     push,
    output logic                     full,
    input  logic [cqe_pkg::IN_W-1:0] i_intervals,
    input  logic [1:0]               i_command,
    output logic                     o_job_valid,
    output cqe_pkg::t_job            o_job,
    input  logic                     i_job_ready
);

    cqe_pkg::t_job r_mem [2];
    logic          r_wr;
    logic          r_rd;
    logic [1:0]    r_cnt;
    cqe_pkg::t_job job_in;
    logic          wr_en;
    logic          rd_en;

    // Saturate and classify the incoming request
    always_comb begin
        job_in.cmd = cqe_pkg::t_cmd'(i_command);
        if (i_intervals > cqe_pkg::IN_W'(cqe_pkg::MAX_INTERVALS)) begin
            job_in.n = cqe_pkg::CNT_W'(cqe_pkg::MAX_INTERVALS);
        end else begin
            job_in.n = cqe_pkg::CNT_W'(i_intervals);
        end
        job_in.err = (job_in.n == '0) ||
                     ((job_in.cmd == cqe_pkg::CMD_SIMPSON) && job_in.n[0]);
    end

    assign full        = (r_cnt == 2'd2);
    assign wr_en       = push && !full;
    assign o_job_valid = (r_cnt != 2'd0);
    assign rd_en       = o_job_valid && i_job_ready;
    assign o_job       = r_mem[r_rd];

    // Store the job
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wr] <= job_in;
        end
    end

    // Advance pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (wr_en) begin
                r_wr <= ~r_wr;
            end
            if (rd_en) begin
                r_rd <= ~r_rd;
            end
            r_cnt <= r_cnt + 2'(wr_en) - 2'(rd_en);
        end
    end

endmodule

// ----- rtl/cqe_div.sv -----
// Restoring divider, one quotient bit per cycle, unsigned operands.
// Depends on cqe_pkg for operand widths.
module cqe_div (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [cqe_pkg::DIV_W-1:0] i_dividend,
    input  logic [cqe_pkg::DSR_W-1:0] i_divisor,
    output logic                      o_done,
    output logic [cqe_pkg::DIV_W-1:0] o_quotient,
    output logic [cqe_pkg::DSR_W-1:0] o_remainder
);

    localparam int CW = $clog2(cqe_pkg::DIV_W + 1);

    logic                      r_busy;
    logic                      r_done;
    logic [CW-1:0]             r_cnt;
    logic [cqe_pkg::DIV_W-1:0] r_quo;
    logic [cqe_pkg::DSR_W-1:0] r_rem;
    logic [cqe_pkg::DSR_W-1:0] r_dsr;
    logic [cqe_pkg::DSR_W:0]   trial;
    logic                      fits;

    assign trial       = {r_rem, r_quo[cqe_pkg::DIV_W-1]};
    assign fits        = (trial >= {1'b0, r_dsr});
    assign o_done      = r_done;
    assign o_quotient  = r_quo;
    assign o_remainder = r_rem;

    // Sequence the iterations
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(cqe_pkg::DIV_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CW'(1);
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Shift in one quotient bit per cycle
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_dsr <= i_divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[cqe_pkg::DIV_W-2:0], fits};
            if (fits) begin
                r_rem <= cqe_pkg::DSR_W'(trial - {1'b0, r_dsr});
            end else begin
                r_rem <= cqe_pkg::DSR_W'(trial);
            end
        end
    end

endmodule

// ----- rtl/cqe_func.sv -----
// Pipelined sample unit: weighted x*cos(2x+1) in Q28, one sample per cycle.
// Angle reduction, quadrant fold, CORDIC rotations, multiply, scale. Uses cqe_pkg.
module cqe_func (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    input  logic signed [cqe_pkg::XW-1:0]     i_x,
    input  logic [1:0]                        i_shift,
    output logic                              o_valid,
    output logic signed [cqe_pkg::TERM_W-1:0] o_term
);

    localparam int NR = cqe_pkg::RED_STAGES;
    localparam int NC = cqe_pkg::CORDIC_ITERATIONS;

    // Reduction stages (index 0 holds the raw angle)
    logic                             r_rv  [NR+1];
    logic signed [cqe_pkg::XW-1:0]    r_rx  [NR+1];
    logic [1:0]                       r_rsh [NR+1];
    logic signed [cqe_pkg::ANG_W-1:0] r_rt  [NR+1];

    // Rotation stages (index 0 holds the folded angle)
    logic                          r_cv  [NC+1];
    logic signed [cqe_pkg::XW-1:0] r_cxp [NC+1];
    logic [1:0]                    r_csh [NC+1];
    logic                          r_neg [NC+1];
    logic signed [cqe_pkg::ZW-1:0] r_ccx [NC+1];
    logic signed [cqe_pkg::ZW-1:0] r_ccy [NC+1];
    logic signed [cqe_pkg::ZW-1:0] r_cz  [NC+1];

    // Multiply and scale stages
    logic                                r_mv;
    logic [1:0]                          r_msh;
    logic signed [2*cqe_pkg::XW-1:0]     r_mp;
    logic                                r_ov;
    logic signed [cqe_pkg::TERM_W-1:0]   r_term;

    logic signed [cqe_pkg::ZW-1:0]       cos_v;
    logic signed [2*cqe_pkg::XW-1:0]     scaled;
    logic signed [cqe_pkg::XW-1:0]       clamped;
    logic signed [cqe_pkg::ANG_W-1:0]    fold_z;
    logic                                fold_neg;

    // Form the angle 2x + 1
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rv[0] <= 1'b0;
        end else begin
            r_rv[0] <= i_valid;
        end
        r_rx[0]  <= i_x;
        r_rsh[0] <= i_shift;
        r_rt[0]  <= (cqe_pkg::ANG_W'(i_x) <<< 1) + cqe_pkg::Q_ONE;
    end

    // Bring the angle into (-pi, pi], one period per stage
    for (genvar k = 0; k < NR; k++) begin : g_red
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_rv[k+1] <= 1'b0;
            end else begin
                r_rv[k+1] <= r_rv[k];
            end
            r_rx[k+1]  <= r_rx[k];
            r_rsh[k+1] <= r_rsh[k];
            if (r_rt[k] > cqe_pkg::Q_PI) begin
                r_rt[k+1] <= r_rt[k] - cqe_pkg::Q_TWO_PI;
            end else if (r_rt[k] <= -cqe_pkg::Q_PI) begin
                r_rt[k+1] <= r_rt[k] + cqe_pkg::Q_TWO_PI;
            end else begin
                r_rt[k+1] <= r_rt[k];
            end
        end
    end

    // Fold into [-pi/2, pi/2] and note the sign flip
    always_comb begin
        fold_neg = 1'b1;
        if (r_rt[NR] > cqe_pkg::Q_HALF_PI) begin
            fold_z = r_rt[NR] - cqe_pkg::Q_PI;
        end else if (r_rt[NR] < -cqe_pkg::Q_HALF_PI) begin
            fold_z = r_rt[NR] + cqe_pkg::Q_PI;
        end else begin
            fold_z   = r_rt[NR];
            fold_neg = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cv[0] <= 1'b0;
        end else begin
            r_cv[0] <= r_rv[NR];
        end
        r_cxp[0] <= r_rx[NR];
        r_csh[0] <= r_rsh[NR];
        r_neg[0] <= fold_neg;
        r_ccx[0] <= cqe_pkg::CORDIC_GAIN;
        r_ccy[0] <= '0;
        r_cz[0]  <= cqe_pkg::ZW'(fold_z);
    end

    // Rotate toward zero angle, one micro-rotation per stage
    for (genvar k = 0; k < NC; k++) begin : g_rot
        logic signed [cqe_pkg::ZW-1:0] dx;
        logic signed [cqe_pkg::ZW-1:0] dy;
        assign dx = r_ccy[k] >>> k;
        assign dy = r_ccx[k] >>> k;
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_cv[k+1] <= 1'b0;
            end else begin
                r_cv[k+1] <= r_cv[k];
            end
            r_cxp[k+1] <= r_cxp[k];
            r_csh[k+1] <= r_csh[k];
            r_neg[k+1] <= r_neg[k];
            if (r_cz[k] >= 0) begin
                r_ccx[k+1] <= r_ccx[k] - dx;
                r_ccy[k+1] <= r_ccy[k] + dy;
                r_cz[k+1]  <= r_cz[k] - cqe_pkg::atan_entry(k);
            end else begin
                r_ccx[k+1] <= r_ccx[k] + dx;
                r_ccy[k+1] <= r_ccy[k] - dy;
                r_cz[k+1]  <= r_cz[k] + cqe_pkg::atan_entry(k);
            end
        end
    end

    // Multiply x by the cosine
    assign cos_v = r_neg[NC] ? -r_ccx[NC] : r_ccx[NC];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mv <= 1'b0;
        end else begin
            r_mv <= r_cv[NC];
        end
        r_msh <= r_csh[NC];
        r_mp  <= (2*cqe_pkg::XW)'(r_cxp[NC]) * (2*cqe_pkg::XW)'(cos_v);
    end

    // Drop the fraction, clamp to 32 bits, apply the weight
    always_comb begin
        scaled = r_mp >>> 28;
        if (scaled > (2*cqe_pkg::XW)'(64'sd2147483647)) begin
            clamped = cqe_pkg::XW'(32'sh7fffffff);
        end else if (scaled < -(2*cqe_pkg::XW)'(64'sd2147483648)) begin
            clamped = cqe_pkg::XW'(32'sh80000000);
        end else begin
            clamped = cqe_pkg::XW'(scaled);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else begin
            r_ov <= r_mv;
        end
        r_term <= cqe_pkg::TERM_W'(clamped) <<< r_msh;
    end

    assign o_valid = r_ov;
    assign o_term  = r_term;

endmodule

// ----- rtl/cqe_back.sv -----
// Back end: sequences one job through step division, the sample sweep,
// the mean division and the final scaling. Uses cqe_pkg, cqe_div, cqe_func.
module cqe_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_job_valid,
    input  cqe_pkg::t_job                 i_job,
    output logic                          o_job_ready,
    input  logic signed [cqe_pkg::XW-1:0] i_lower,
    input  logic signed [cqe_pkg::XW-1:0] i_upper,
    output logic                          o_res_valid,
    output cqe_pkg::t_result              o_res,
    input  logic                          i_res_ready
);

    localparam int LAT_W = $clog2(cqe_pkg::FUNC_LATENCY + 1);
    localparam int MC_W  = $clog2(cqe_pkg::MUL_W);

    typedef enum logic [6:0] {
        ST_IDLE   = 7'b0000001,
        ST_DIV1   = 7'b0000010,
        ST_SAMPLE = 7'b0000100,
        ST_DRAIN  = 7'b0001000,
        ST_DIV2   = 7'b0010000,
        ST_MUL    = 7'b0100000,
        ST_EMIT   = 7'b1000000
    } t_state;

    t_state                              r_state;
    cqe_pkg::t_job                       r_job;
    logic                                r_err;
    logic signed [cqe_pkg::SPAN_W-1:0]   r_span;
    logic signed [cqe_pkg::QA_W-1:0]     r_q;
    logic [cqe_pkg::CNT_W-1:0]           r_r;
    logic signed [cqe_pkg::QA_W-1:0]     r_qacc;
    logic [cqe_pkg::CNT_W-1:0]           r_racc;
    logic [cqe_pkg::CNT_W-1:0]           r_i;
    logic signed [cqe_pkg::DIV_W-1:0]    r_acc;
    logic [LAT_W-1:0]                    r_lat;
    logic [cqe_pkg::PROD_W-1:0]          r_mcand;
    logic [cqe_pkg::MUL_W-1:0]           r_mplier;
    logic [cqe_pkg::PROD_W-1:0]          r_prod;
    logic [MC_W-1:0]                     r_mcnt;
    logic                                r_neg;

    logic signed [cqe_pkg::SPAN_W-1:0]   span_now;
    logic [cqe_pkg::SPAN_W-1:0]          span_mag_now;
    logic [cqe_pkg::SPAN_W-1:0]          span_mag;
    logic [cqe_pkg::DIV_W-1:0]           acc_mag;
    logic                                div_start;
    logic [cqe_pkg::DIV_W-1:0]           div_dividend;
    logic [cqe_pkg::DSR_W-1:0]           div_divisor;
    logic                                div_done;
    logic [cqe_pkg::DIV_W-1:0]           div_quo;
    logic [cqe_pkg::DSR_W-1:0]           div_rem;
    logic [cqe_pkg::DSR_W-1:0]           n_ext;
    logic signed [cqe_pkg::QA_W-1:0]     quo_s;
    logic [cqe_pkg::CNT_W-1:0]           rem_n;
    logic                                rem_nz;
    logic [cqe_pkg::CNT_W:0]             racc_sum;
    logic signed [cqe_pkg::QA_W-1:0]     trunc_v;
    logic signed [cqe_pkg::XW-1:0]       x_now;
    logic                                is_edge;
    logic                                f_in_valid;
    logic [1:0]                          f_shift;
    logic                                f_valid;
    logic signed [cqe_pkg::TERM_W-1:0]   f_term;
    logic signed [cqe_pkg::PROD_W:0]     prod_s;
    logic signed [cqe_pkg::PROD_W:0]     prod_q;

    cqe_div u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (div_start),
        .i_dividend  (div_dividend),
        .i_divisor   (div_divisor),
        .o_done      (div_done),
        .o_quotient  (div_quo),
        .o_remainder (div_rem)
    );

    cqe_func u_func (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (f_in_valid),
        .i_x     (x_now),
        .i_shift (f_shift),
        .o_valid (f_valid),
        .o_term  (f_term)
    );

    // Span and magnitudes
    assign span_now     = {i_upper[cqe_pkg::XW-1], i_upper} - {i_lower[cqe_pkg::XW-1], i_lower};
    assign span_mag_now = span_now[cqe_pkg::SPAN_W-1] ? -span_now : span_now;
    assign span_mag     = r_span[cqe_pkg::SPAN_W-1] ? -r_span : r_span;
    assign acc_mag      = r_acc[cqe_pkg::DIV_W-1] ? -r_acc : r_acc;
    assign n_ext        = cqe_pkg::DSR_W'(r_job.n);

    // Divider requests: step at job start, mean after the sweep drains
    always_comb begin
        div_start    = 1'b0;
        div_dividend = cqe_pkg::DIV_W'(span_mag_now);
        div_divisor  = cqe_pkg::DSR_W'(i_job.n);
        if (r_state == ST_IDLE) begin
            div_start = i_job_valid && !i_job.err;
        end else if (r_state == ST_DRAIN) begin
            div_start    = (r_lat == '0);
            div_dividend = acc_mag;
            case (r_job.cmd)
                cqe_pkg::CMD_TRAP:    div_divisor = n_ext << 1;
                cqe_pkg::CMD_SIMPSON: div_divisor = (n_ext << 1) + n_ext;
                default:              div_divisor = n_ext;
            endcase
        end
    end

    // Floor step quotient and remainder from the magnitude division
    assign rem_n  = cqe_pkg::CNT_W'(div_rem);
    assign rem_nz = (rem_n != '0);
    assign quo_s  = cqe_pkg::QA_W'(div_quo);

    // Current abscissa a + trunc(i*span/n)
    assign racc_sum = {1'b0, r_racc} + {1'b0, r_r};
    assign trunc_v  = r_qacc + ((r_span[cqe_pkg::SPAN_W-1] && (r_racc != '0)) ?
                      cqe_pkg::QA_W'(1) : cqe_pkg::QA_W'(0));
    assign x_now    = cqe_pkg::XW'(cqe_pkg::QA_W'(i_lower) + trunc_v);
    assign is_edge  = (r_i == '0) || (r_i == r_job.n);

    // Weight per method as a shift, with zero weights skipped
    always_comb begin
        f_shift    = 2'd0;
        f_in_valid = 1'b0;
        unique case (r_job.cmd)
            cqe_pkg::CMD_LEFT:  f_in_valid = (r_i != r_job.n);
            cqe_pkg::CMD_RIGHT: f_in_valid = (r_i != '0);
            cqe_pkg::CMD_TRAP: begin
                f_in_valid = 1'b1;
                f_shift    = is_edge ? 2'd0 : 2'd1;
            end
            cqe_pkg::CMD_SIMPSON: begin
                f_in_valid = 1'b1;
                f_shift    = is_edge ? 2'd0 : (r_i[0] ? 2'd2 : 2'd1);
            end
        endcase
        if (r_state != ST_SAMPLE) begin
            f_in_valid = 1'b0;
        end
    end

    // Accumulate weighted samples
    always_ff @(posedge i_clk) begin
        if (r_state == ST_IDLE) begin
            r_acc <= '0;
        end else if (f_valid) begin
            r_acc <= r_acc + cqe_pkg::DIV_W'(f_term);
        end
    end

    // Sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            unique case (r_state)
                ST_IDLE: begin
                    if (i_job_valid) begin
                        r_state <= i_job.err ? ST_EMIT : ST_DIV1;
                    end
                end
                ST_DIV1: begin
                    if (div_done) begin
                        r_state <= ST_SAMPLE;
                    end
                end
                ST_SAMPLE: begin
                    if (r_i == r_job.n) begin
                        r_state <= ST_DRAIN;
                    end
                end
                ST_DRAIN: begin
                    if (r_lat == '0) begin
                        r_state <= ST_DIV2;
                    end
                end
                ST_DIV2: begin
                    if (div_done) begin
                        r_state <= ST_MUL;
                    end
                end
                ST_MUL: begin
                    if (r_mcnt == MC_W'(cqe_pkg::MUL_W - 1)) begin
                        r_state <= ST_EMIT;
                    end
                end
                ST_EMIT: begin
                    if (i_res_ready) begin
                        r_state <= ST_IDLE;
                    end
                end
            endcase
        end
    end

    // Datapath registers per state
    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                r_job  <= i_job;
                r_err  <= i_job.err;
                r_span <= span_now;
                r_prod <= '0;
            end
            ST_DIV1: begin
                r_qacc <= '0;
                r_racc <= '0;
                r_i    <= '0;
                if (r_span[cqe_pkg::SPAN_W-1]) begin
                    r_q <= -quo_s - (rem_nz ? cqe_pkg::QA_W'(1) : cqe_pkg::QA_W'(0));
                    r_r <= rem_nz ? (r_job.n - rem_n) : rem_n;
                end else begin
                    r_q <= quo_s;
                    r_r <= rem_n;
                end
            end
            ST_SAMPLE: begin
                r_i <= r_i + cqe_pkg::CNT_W'(1);
                if (racc_sum >= {1'b0, r_job.n}) begin
                    r_racc <= cqe_pkg::CNT_W'(racc_sum - {1'b0, r_job.n});
                    r_qacc <= r_qacc + r_q + cqe_pkg::QA_W'(1);
                end else begin
                    r_racc <= cqe_pkg::CNT_W'(racc_sum);
                    r_qacc <= r_qacc + r_q;
                end
                r_lat <= LAT_W'(cqe_pkg::FUNC_LATENCY);
            end
            ST_DRAIN: begin
                r_lat <= r_lat - LAT_W'(1);
            end
            ST_DIV2: begin
                r_mplier <= cqe_pkg::MUL_W'(div_quo);
                r_mcand  <= cqe_pkg::PROD_W'(span_mag);
                r_prod   <= '0;
                r_mcnt   <= '0;
                r_neg    <= r_acc[cqe_pkg::DIV_W-1] ^ r_span[cqe_pkg::SPAN_W-1];
            end
            ST_MUL: begin
                if (r_mplier[0]) begin
                    r_prod <= r_prod + r_mcand;
                end
                r_mcand  <= r_mcand << 1;
                r_mplier <= r_mplier >> 1;
                r_mcnt   <= r_mcnt + MC_W'(1);
            end
            default: begin
            end
        endcase
    end

    // Sign and scale the product
    assign prod_s = $signed({1'b0, r_prod});
    assign prod_q = r_neg ? -prod_s : prod_s;

    assign o_job_ready    = (r_state == ST_IDLE);
    assign o_res_valid    = (r_state == ST_EMIT);
    assign o_res.err      = r_err;
    assign o_res.integral = r_err ? '0 : cqe_pkg::RES_W'(prod_q >>> 28);

    // Checks
    a_sweep_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SAMPLE && r_i == r_job.n) |=> (r_state == ST_DRAIN))
        else $error("sweep did not stop at the last sample");

    a_sample_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        f_valid |-> (r_state == ST_SAMPLE || r_state == ST_DRAIN))
        else $error("sample returned outside the sweep");

    a_div_owner: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> (r_state == ST_DIV1 || r_state == ST_DIV2))
        else $error("divider finished with no division pending");

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && o_res.err) |-> (o_res.integral == '0))
        else $error("rejected request produced a nonzero integral");

endmodule

// ----- sim/composite_quadrature_engine_tb.sv -----
// Self-checking testbench for composite_quadrature_engine: a bit-exact predictor of the
// fixed-point quadrature drives a store of expected integrals checked in order.
// Depends on rtl/cqe_pkg.sv and the engine RTL only.
module composite_quadrature_engine_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int  DRAIN_CYCLES = 300;
    localparam longint CYCLE_LIMIT = 40_000_000;

    logic                             i_clk;
    logic                             i_rst_n;
    logic                             push;
    logic                             full;
    logic [cqe_pkg::IN_W-1:0]         i_intervals;
    logic [1:0]                       i_command;
    logic                             empty;
    logic                             pop;
    logic signed [cqe_pkg::RES_W-1:0] o_integral;
    logic                             o_error_flag;
    logic                             i_cfg_valid;
    logic                             o_cfg_ready;
    logic                             i_cfg_index;
    logic [cqe_pkg::XW-1:0]           i_cfg_data;

    composite_quadrature_engine dut (.*);

    // Predictor state: the two bounds as last written
    longint lo_bound;
    longint hi_bound;
    cqe_pkg::t_result integral_fifo[$];
    int      mismatch_count;
    int      sent_count;
    int      checked_count;
    int      sender_idle_pct;
    int      receiver_stall_pct;
    longint  cycle_count = 0;

    // Arctangent of 2^-i in Q28 for the rotation loop
    function automatic longint arctan_q28(int i);
        longint tab[12] = '{210828714, 124459457, 65760959, 33381290, 16755422, 8385879,
                            4193963, 2097109, 1048571, 524287, 262144, 131072};
        if (i < 12) return tab[i];
        if (i <= 28) return longint'(1) << (28 - i);
        return 0;
    endfunction

    // Cosine of a Q28 angle: reduce into (-pi, pi], fold to the right half, rotate
    function automatic longint cosine_q28(longint theta);
        longint r, cx, cy, z, dx, dy;
        bit     flip;
        r = theta % 1686629713;
        flip = 0;
        cx = 163008218;
        cy = 0;
        if (r < 0) r += 1686629713;
        if (r > 843314857) r -= 1686629713;
        if (r > 421657428) begin
            r -= 843314857;
            flip = 1;
        end else if (r < -421657428) begin
            r += 843314857;
            flip = 1;
        end
        z = r;
        for (int i = 0; i < cqe_pkg::CORDIC_ITERATIONS; i++) begin
            dx = cy >>> i;
            dy = cx >>> i;
            if (z >= 0) begin
                cx -= dx;
                cy += dy;
                z -= arctan_q28(i);
            end else begin
                cx += dx;
                cy -= dy;
                z += arctan_q28(i);
            end
        end
        return flip ? -cx : cx;
    endfunction

    // f(x) = x*cos(2x+1), floored and clamped to 32 bits
    function automatic longint integrand_q28(longint x);
        longint v;
        v = (x * cosine_q28(2 * x + 268435456)) >>> 28;
        if (v > 64'sd2147483647) v = 64'sd2147483647;
        if (v < -64'sd2147483648) v = -64'sd2147483648;
        return v;
    endfunction

    // Weighted sum over all abscissae, then mean times interval length
    function automatic cqe_pkg::t_result integral_predict(int unsigned n_raw,
                                                          cqe_pkg::t_cmd cmd);
        cqe_pkg::t_result r;
        longint  n, span, sum, w, div, res;
        n = (n_raw > cqe_pkg::MAX_INTERVALS) ? cqe_pkg::MAX_INTERVALS : n_raw;
        r.integral = '0;
        r.err = 1'b1;
        if (n == 0 || (cmd == cqe_pkg::CMD_SIMPSON && n % 2 == 1)) return r;
        span = hi_bound - lo_bound;
        sum = 0;
        for (longint i = 0; i <= n; i++) begin
            case (cmd)
                cqe_pkg::CMD_LEFT:  w = (i < n) ? 1 : 0;
                cqe_pkg::CMD_RIGHT: w = (i > 0) ? 1 : 0;
                cqe_pkg::CMD_TRAP:  w = (i == 0 || i == n) ? 1 : 2;
                default:            w = (i == 0 || i == n) ? 1 : ((i % 2 == 1) ? 4 : 2);
            endcase
            if (w != 0) sum += w * integrand_q28(lo_bound + (i * span) / n);
        end
        div = n * ((cmd == cqe_pkg::CMD_TRAP) ? 2 : (cmd == cqe_pkg::CMD_SIMPSON) ? 3 : 1);
        res = ((sum / div) * span) >>> 28;
        r.integral = cqe_pkg::RES_W'(res);
        r.err = 1'b0;
        return r;
    endfunction

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Abort on a hung run
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, integral_fifo.size());
            $display("FAIL composite_quadrature_engine");
            $finish;
        end
    end

    task automatic report_mismatch(string what, longint got, longint want);
        mismatch_count++;
        $display("mismatch %s: got %0d expected %0d (result %0d)",
                 what, got, want, checked_count);
    endtask

    // Check each popped transaction against the oldest expectation, then stall at random
    always @(posedge i_clk) begin
        cqe_pkg::t_result want;
        if (i_rst_n && pop && !empty) begin
            if (integral_fifo.size() == 0) begin
                report_mismatch("unexpected result", o_integral, 0);
            end else begin
                want = integral_fifo.pop_front();
                if (o_integral !== want.integral)
                    report_mismatch("integral", o_integral, want.integral);
                if (o_error_flag !== want.err)
                    report_mismatch("error_flag", o_error_flag, want.err);
            end
            checked_count++;
        end
        if (!i_rst_n)
            pop <= 1'b0;
        else
            pop <= ($urandom_range(99) >= receiver_stall_pct);
    end

    // Send one request; the expectation is recorded at the accepting edge
    task automatic send_request(int unsigned n, cqe_pkg::t_cmd cmd);
        if ($urandom_range(99) < sender_idle_pct) begin
            push <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
        push <= 1'b1;
        i_intervals <= cqe_pkg::IN_W'(n);
        i_command <= cmd;
        do @(posedge i_clk); while (full);
        integral_fifo.push_back(integral_predict(n, cmd));
        sent_count++;
    endtask

    // Hold off until every result is back and the engine has settled
    task automatic wait_idle();
        push <= 1'b0;
        @(posedge i_clk);
        while (integral_fifo.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic write_bound(logic idx, longint value);
        wait_idle();
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= cqe_pkg::XW'(value);
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        if (idx == cqe_pkg::REG_LOWER) lo_bound = longint'($signed(cqe_pkg::XW'(value)));
        else hi_bound = longint'($signed(cqe_pkg::XW'(value)));
    endtask

    function automatic int unsigned random_count();
        int p;
        p = $urandom_range(999);
        if (p < 4) return $urandom_range(cqe_pkg::MAX_INTERVALS, 2 ** cqe_pkg::IN_W - 1);
        if (p < 8) return $urandom_range(2, cqe_pkg::MAX_INTERVALS);
        if (p < 60) return $urandom_range(41, 1500);
        if (p < 100) return $urandom_range(0, 1);
        return $urandom_range(2, 40);
    endfunction

    // Every method at the count extremes, including rejects and saturation
    task automatic test_methods();
        for (int c = 0; c < 4; c++) begin
            send_request(0, cqe_pkg::t_cmd'(c));
            send_request(1, cqe_pkg::t_cmd'(c));
            send_request(2, cqe_pkg::t_cmd'(c));
            send_request(7, cqe_pkg::t_cmd'(c));
        end
        send_request(cqe_pkg::MAX_INTERVALS, cqe_pkg::CMD_TRAP);
        send_request(2 ** cqe_pkg::IN_W - 1, cqe_pkg::CMD_SIMPSON);
        send_request(cqe_pkg::MAX_INTERVALS + 1, cqe_pkg::CMD_LEFT);
    endtask

    // Bound extremes, reversed and equal bounds
    task automatic test_bounds();
        write_bound(cqe_pkg::REG_LOWER, -64'sd2147483648);
        write_bound(cqe_pkg::REG_UPPER, 64'sd2147483647);
        for (int c = 0; c < 4; c++) send_request(4, cqe_pkg::t_cmd'(c));
        write_bound(cqe_pkg::REG_LOWER, 64'sd2147483647);
        write_bound(cqe_pkg::REG_UPPER, -64'sd2147483648);
        send_request(6, cqe_pkg::CMD_SIMPSON);
        send_request(5, cqe_pkg::CMD_RIGHT);
        write_bound(cqe_pkg::REG_UPPER, 64'sd2147483647);
        send_request(3, cqe_pkg::CMD_TRAP);
    endtask

    // Random requests under one idling mix, with fresh random bounds
    task automatic test_random(int idle_pct, int stall_pct, int items);
        wait_idle();
        sender_idle_pct = idle_pct;
        receiver_stall_pct = stall_pct;
        write_bound(cqe_pkg::REG_LOWER, longint'($signed($urandom())));
        write_bound(cqe_pkg::REG_UPPER,
                    ($urandom_range(3) == 0) ? longint'($signed($urandom()))
                    : lo_bound + $urandom_range(0, 2 ** 30) - 2 ** 28);
        for (int k = 0; k < items; k++)
            send_request(random_count(), cqe_pkg::t_cmd'($urandom_range(3)));
    endtask

    initial begin
        push = 1'b0;
        i_intervals = '0;
        i_command = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = 1'b0;
        i_cfg_data = '0;
        i_rst_n = 1'b0;
        mismatch_count = 0;
        sent_count = 0;
        checked_count = 0;
        sender_idle_pct = 0;
        receiver_stall_pct = 0;
        lo_bound = -268435456;
        hi_bound = 268435456;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_methods();
        test_bounds();
        test_random(0, 0, 20);
        test_random(58, 0, 20);
        test_random(0, 58, 20);
        test_random(29, 29, 20);

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("covered %0d requests over all methods, bound extremes and four idling mixes;",
                 sent_count);
        $display("%0d results checked, %0d mismatches", checked_count, mismatch_count);
        if (mismatch_count == 0 && integral_fifo.size() == 0)
            $display("PASS composite_quadrature_engine");
        else
            $display("FAIL composite_quadrature_engine");
        $finish;
    end
endmodule

// ----- composite_quadrature_engine.f -----
rtl/cqe_pkg.sv
rtl/cqe_front.sv
rtl/cqe_div.sv
rtl/cqe_func.sv
rtl/cqe_back.sv
rtl/composite_quadrature_engine.sv
sim/composite_quadrature_engine_tb.sv
